// File: hw/rtl/bpi_pkg.sv
// Shared package for the bicycle pose integrator.
// Holds fixed-point constants, the arctangent table, sequencer state types and unit request types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpi_pkg;

   // CORDIC iteration count, valid from 8 to 32.
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_IW    = 5;
   localparam int CORDIC_CW    = $clog2(CORDIC_STEPS + 1);
   localparam int CD_W         = 34;

   localparam logic signed [CD_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CD_W-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [CD_W-1:0] HALF_TURN    = 34'sd2147483648;

   localparam logic [31:0] TURN_PER_RAD     = 32'd683565276;
   localparam logic [63:0] DEN_STRAIGHT     = 64'd1073741824000000;
   localparam logic [19:0] MICRO            = 20'd1000000;
   localparam logic [15:0] STEER_LIMIT      = 16'd25735;
   localparam logic [15:0] CAR_LENGTH_RESET = 16'd2000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TIME, ST_HCORD, ST_SX, ST_SY, ST_AB, ST_ACORD, ST_GAIN, ST_DEN,
      ST_DA, ST_DCORD, ST_LC, ST_DX, ST_DY, ST_RX1, ST_RX2, ST_RY1, ST_RY2, ST_UPD
   } seq_state_type;

   typedef enum logic [2:0] {
      MD_IDLE, MD_MUL, MD_ACC, MD_HALF, MD_DIV, MD_DONE
   } md_state_type;

   typedef enum logic [1:0] {
      CD_IDLE, CD_RUN, CD_DONE
   } cd_state_type;

   typedef struct packed {
      logic        start;
      logic        divide;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] den;
   } md_req_type;

   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cd_req_type;

   // Arctangent of 2^-i as a 32-bit binary angle.
   function automatic logic [31:0] atan_entry(input logic [CORDIC_IW-1:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         5'd31: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bpi_muldiv.sv
// Shared multiply and rounded-divide unit: 64x64 product from four 32x32 partial
// products, then optionally round(a*b/den) by a 128-step restoring divider.
// Depends on bpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpi_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bpi_pkg::md_req_type req,
   output logic                     done,
   output logic [63:0]              result
);

   bpi_pkg::md_state_type state_ff, state_in;

   logic [63:0]  a_ff, b_ff, den_ff, pp_ff, rem_ff, quo_ff;
   logic         div_ff;
   logic [127:0] acc_ff, num_ff, pp_shift;
   logic [1:0]   k_ff;
   logic [6:0]   cnt_ff;
   logic [31:0]  a_half, b_half;
   logic [64:0]  trial, diff;
   logic         ge;

   assign a_half = k_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half = k_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign trial  = {rem_ff, num_ff[127]};
   assign ge     = trial >= {1'b0, den_ff};
   assign diff   = trial - {1'b0, den_ff};

   always_comb begin
      unique case (k_ff)
         2'd0:       pp_shift = {64'd0, pp_ff};
         2'd1, 2'd2: pp_shift = {32'd0, pp_ff, 32'd0};
         2'd3:       pp_shift = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpi_pkg::MD_IDLE: if (req.start) state_in = bpi_pkg::MD_MUL;
         bpi_pkg::MD_MUL:  state_in = bpi_pkg::MD_ACC;
         bpi_pkg::MD_ACC: begin
            if (k_ff == 2'd3) state_in = div_ff ? bpi_pkg::MD_HALF : bpi_pkg::MD_DONE;
            else              state_in = bpi_pkg::MD_MUL;
         end
         bpi_pkg::MD_HALF: state_in = bpi_pkg::MD_DIV;
         bpi_pkg::MD_DIV:  if (cnt_ff == 7'd127) state_in = bpi_pkg::MD_DONE;
         bpi_pkg::MD_DONE: state_in = bpi_pkg::MD_IDLE;
         default:          state_in = bpi_pkg::MD_IDLE;
      endcase
   end

   always_comb begin
      done   = (state_ff == bpi_pkg::MD_DONE);
      result = div_ff ? quo_ff : acc_ff[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bpi_pkg::MD_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         bpi_pkg::MD_IDLE: begin
            if (req.start) begin
               a_ff   <= req.a;
               b_ff   <= req.b;
               den_ff <= req.den;
               div_ff <= req.divide;
               acc_ff <= '0;
               k_ff   <= '0;
            end
         end
         bpi_pkg::MD_MUL: pp_ff <= a_half * b_half;
         bpi_pkg::MD_ACC: begin
            acc_ff <= acc_ff + pp_shift;
            k_ff   <= k_ff + 2'd1;
         end
         bpi_pkg::MD_HALF: begin
            // Half the divisor is added first so the quotient rounds half up.
            num_ff <= acc_ff + {65'd0, den_ff[63:1]};
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         bpi_pkg::MD_DIV: begin
            rem_ff <= ge ? diff[63:0] : trial[63:0];
            num_ff <= {num_ff[126:0], 1'b0};
            quo_ff <= {quo_ff[62:0], ge};
            cnt_ff <= cnt_ff + 7'd1;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/bpi_cordic.sv
// Iterative rotation CORDIC: cosine and sine in Q30 of a 32-bit binary angle,
// one micro-rotation per cycle with quadrant folding up front.
// Depends on bpi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpi_cordic (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire bpi_pkg::cd_req_type                   req,
   output logic                                       done,
   output logic signed [bpi_pkg::CD_W-1:0]            cos_q30,
   output logic signed [bpi_pkg::CD_W-1:0]            sin_q30
);

   bpi_pkg::cd_state_type state_ff, state_in;

   logic signed [bpi_pkg::CD_W-1:0] x_ff, y_ff, z_ff, z_start, x_sh, y_sh, atan_s;
   logic                            flip_ff;
   logic [bpi_pkg::CORDIC_CW-1:0]   i_ff;

   assign z_start = bpi_pkg::CD_W'(signed'(req.angle));
   assign x_sh    = x_ff >>> i_ff[bpi_pkg::CORDIC_IW-1:0];
   assign y_sh    = y_ff >>> i_ff[bpi_pkg::CORDIC_IW-1:0];
   assign atan_s  = signed'({2'b00, bpi_pkg::atan_entry(i_ff[bpi_pkg::CORDIC_IW-1:0])});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpi_pkg::CD_IDLE: if (req.start) state_in = bpi_pkg::CD_RUN;
         bpi_pkg::CD_RUN: begin
            if (i_ff == bpi_pkg::CORDIC_CW'(bpi_pkg::CORDIC_STEPS - 1))
               state_in = bpi_pkg::CD_DONE;
         end
         bpi_pkg::CD_DONE: state_in = bpi_pkg::CD_IDLE;
         default:          state_in = bpi_pkg::CD_IDLE;
      endcase
   end

   always_comb begin
      done    = (state_ff == bpi_pkg::CD_DONE);
      cos_q30 = flip_ff ? -x_ff : x_ff;
      sin_q30 = flip_ff ? -y_ff : y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bpi_pkg::CD_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         bpi_pkg::CD_IDLE: begin
            if (req.start) begin
               x_ff <= bpi_pkg::CORDIC_GAIN;
               y_ff <= '0;
               i_ff <= '0;
               // Angles beyond a quarter turn are folded by a half turn and negated after.
               if (z_start > bpi_pkg::QUARTER_TURN) begin
                  z_ff    <= z_start - bpi_pkg::HALF_TURN;
                  flip_ff <= 1'b1;
               end else if (z_start < -bpi_pkg::QUARTER_TURN) begin
                  z_ff    <= z_start + bpi_pkg::HALF_TURN;
                  flip_ff <= 1'b1;
               end else begin
                  z_ff    <= z_start;
                  flip_ff <= 1'b0;
               end
            end
         end
         bpi_pkg::CD_RUN: begin
            if (z_ff >= 0) begin
               x_ff <= x_ff - y_sh;
               y_ff <= y_ff + x_sh;
               z_ff <= z_ff - atan_s;
            end else begin
               x_ff <= x_ff + y_sh;
               y_ff <= y_ff - x_sh;
               z_ff <= z_ff + atan_s;
            end
            i_ff <= i_ff + bpi_pkg::CORDIC_CW'(1);
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/bicycle_pose_integrator.sv
// Top level of the bicycle pose integrator: handshakes, sequencer and pose state.
// Depends on bpi_pkg, bpi_muldiv and bpi_cordic.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    elapsed time, load flag, speed, steering
// rsp       out        rsp_valid/rsp_ready    pose x, pose y, heading, saturated flag
// csr       in         csr_valid/csr_ready    car length (wheelbase)
//
// The time one transfer on req takes is set by the shared multiply/divide unit, whose
// 128-step restoring divider runs twice on a straight step, when the held steering is
// zero, and four times on an arc. Reset is synchronous and active high; it clears the
// pose, the held control and restores the car length to 2000 mm. req_ready is high
// only while the sequencer is idle; a finished result waits in the output register,
// so the next req transfer can be taken while rsp is stalled. csr is always ready.

module bicycle_pose_integrator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [19:0]        req_elapsed_time,
   input  wire logic               req_load_control,
   input  wire logic signed [15:0] req_new_speed,
   input  wire logic signed [15:0] req_new_steering,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_pose_x,
   output logic signed [31:0]      rsp_pose_y,
   output logic [15:0]             rsp_pose_heading,
   output logic                    rsp_saturated,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_car_length
);

   bpi_pkg::seq_state_type state_ff, state_in;

   bpi_pkg::md_req_type md_req;
   bpi_pkg::cd_req_type cd_req;
   logic                md_done, cd_done, md_op, cd_op, issued_ff, upd_fire;
   logic [63:0]         md_res;
   logic signed [33:0]  cd_cos, cd_sin;

   // Architectural state.
   logic signed [31:0] pos_x_ff, pos_y_ff;
   logic [15:0]        head_ff, car_len_ff;
   logic signed [15:0] speed_ff, steer_ff;

   // Per-step working registers.
   logic [19:0]        et_ff;
   logic [35:0]        tm_ff;
   logic               tneg_ff;
   logic signed [33:0] ch_ff, sh_ff, cd_ff, sd_ff;
   logic [31:0]        ab_ff, ca_ff, sa_ff, da_ff;
   logic [63:0]        g_ff, den_ff, lc_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [64:0] acc_ff;
   logic signed [63:0] wx_ff, wy_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic [15:0]        rsp_head_ff;
   logic               rsp_sat_ff;

   // Derived operands.
   logic [15:0]        speed_mag, steer_mag, steer_clip, len;
   logic [33:0]        ch_mag, sh_mag, sd_mag;
   logic signed [34:0] v_q30;
   logic [34:0]        v_mag;
   logic [32:0]        dx_mag, dy_mag;
   logic               rot_neg;
   logic signed [64:0] rot_prod;
   logic signed [65:0] rot_sum, sum_x, sum_y;
   logic signed [31:0] new_x, new_y;
   logic               sat_x, sat_y;
   logic [31:0]        turn, turn_round;
   logic [15:0]        head_new;

   // Signed offset from sign and magnitude, magnitude clipped to 2^31.
   function automatic logic signed [32:0] clip_local(input logic neg, input logic [63:0] m);
      logic signed [32:0] c;
      c = (m > 64'd2147483648) ? 33'sd2147483648 : signed'(m[32:0]);
      return neg ? -c : c;
   endfunction

   bpi_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .req    (md_req),
      .done   (md_done),
      .result (md_res)
   );

   bpi_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .req     (cd_req),
      .done    (cd_done),
      .cos_q30 (cd_cos),
      .sin_q30 (cd_sin)
   );

   assign speed_mag  = speed_ff[15] ? 16'(-speed_ff) : 16'(speed_ff);
   assign steer_mag  = steer_ff[15] ? 16'(-steer_ff) : 16'(steer_ff);
   assign steer_clip = (steer_mag > bpi_pkg::STEER_LIMIT) ? bpi_pkg::STEER_LIMIT : steer_mag;
   assign len        = (car_len_ff == 16'd0) ? 16'd1 : car_len_ff;
   assign ch_mag     = ch_ff[33] ? 34'(-ch_ff) : 34'(ch_ff);
   assign sh_mag     = sh_ff[33] ? 34'(-sh_ff) : 34'(sh_ff);
   assign sd_mag     = sd_ff[33] ? 34'(-sd_ff) : 34'(sd_ff);
   assign v_q30      = 35'sd1073741824 - 35'(cd_ff);
   assign v_mag      = v_q30[34] ? 35'(-v_q30) : 35'(v_q30);
   assign dx_mag     = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign dy_mag     = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign upd_fire   = (state_ff == bpi_pkg::ST_UPD) && (!rsp_valid_ff || rsp_ready);

   // Rotation of the local arc offset into the world frame, one product per state.
   always_comb begin
      unique case (state_ff)
         bpi_pkg::ST_RX1: rot_neg = dx_ff[32] ^ ch_ff[33];
         bpi_pkg::ST_RX2: rot_neg = ~(dy_ff[32] ^ sh_ff[33]);
         bpi_pkg::ST_RY1: rot_neg = dx_ff[32] ^ sh_ff[33];
         bpi_pkg::ST_RY2: rot_neg = dy_ff[32] ^ ch_ff[33];
         default:         rot_neg = 1'b0;
      endcase
      rot_prod = rot_neg ? -signed'({1'b0, md_res}) : signed'({1'b0, md_res});
      rot_sum  = 66'(acc_ff) + 66'(rot_prod) + 66'sd536870912;
   end

   // Position update with saturation, and the heading change on an arc.
   always_comb begin
      sum_x = 66'(pos_x_ff) + 66'(wx_ff);
      sum_y = 66'(pos_y_ff) + 66'(wy_ff);
      sat_x = 1'b0;
      sat_y = 1'b0;
      if (sum_x > 66'sd2147483647) begin
         new_x = 32'sh7FFFFFFF;
         sat_x = 1'b1;
      end else if (sum_x < -66'sd2147483648) begin
         new_x = 32'sh80000000;
         sat_x = 1'b1;
      end else begin
         new_x = signed'(sum_x[31:0]);
      end
      if (sum_y > 66'sd2147483647) begin
         new_y = 32'sh7FFFFFFF;
         sat_y = 1'b1;
      end else if (sum_y < -66'sd2147483648) begin
         new_y = 32'sh80000000;
         sat_y = 1'b1;
      end else begin
         new_y = signed'(sum_y[31:0]);
      end
      turn       = steer_ff[15] ? (32'd0 - da_ff) : da_ff;
      turn_round = turn + 32'h00008000;
      head_new   = (steer_ff == 16'sd0) ? head_ff : head_ff + turn_round[31:16];
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bpi_pkg::ST_IDLE:  if (req_valid) state_in = bpi_pkg::ST_TIME;
         bpi_pkg::ST_TIME:  if (md_done) state_in = bpi_pkg::ST_HCORD;
         bpi_pkg::ST_HCORD: begin
            if (cd_done)
               state_in = (steer_ff == 16'sd0) ? bpi_pkg::ST_SX : bpi_pkg::ST_AB;
         end
         bpi_pkg::ST_SX:    if (md_done) state_in = bpi_pkg::ST_SY;
         bpi_pkg::ST_SY:    if (md_done) state_in = bpi_pkg::ST_UPD;
         bpi_pkg::ST_AB:    if (md_done) state_in = bpi_pkg::ST_ACORD;
         bpi_pkg::ST_ACORD: if (cd_done) state_in = bpi_pkg::ST_GAIN;
         bpi_pkg::ST_GAIN:  if (md_done) state_in = bpi_pkg::ST_DEN;
         bpi_pkg::ST_DEN:   if (md_done) state_in = bpi_pkg::ST_DA;
         bpi_pkg::ST_DA:    if (md_done) state_in = bpi_pkg::ST_DCORD;
         bpi_pkg::ST_DCORD: if (cd_done) state_in = bpi_pkg::ST_LC;
         bpi_pkg::ST_LC:    if (md_done) state_in = bpi_pkg::ST_DX;
         bpi_pkg::ST_DX:    if (md_done) state_in = bpi_pkg::ST_DY;
         bpi_pkg::ST_DY:    if (md_done) state_in = bpi_pkg::ST_RX1;
         bpi_pkg::ST_RX1:   if (md_done) state_in = bpi_pkg::ST_RX2;
         bpi_pkg::ST_RX2:   if (md_done) state_in = bpi_pkg::ST_RY1;
         bpi_pkg::ST_RY1:   if (md_done) state_in = bpi_pkg::ST_RY2;
         bpi_pkg::ST_RY2:   if (md_done) state_in = bpi_pkg::ST_UPD;
         bpi_pkg::ST_UPD:   if (!rsp_valid_ff || rsp_ready) state_in = bpi_pkg::ST_IDLE;
         default:           state_in = bpi_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs: operand selection for the shared units.
   always_comb begin
      md_req = '0;
      cd_req = '0;
      md_op  = 1'b0;
      cd_op  = 1'b0;
      unique case (state_ff)
         bpi_pkg::ST_TIME: begin
            md_op    = 1'b1;
            md_req.a = 64'(et_ff);
            md_req.b = 64'(speed_mag);
         end
         bpi_pkg::ST_HCORD: begin
            cd_op        = 1'b1;
            cd_req.angle = {head_ff, 16'h0000};
         end
         bpi_pkg::ST_SX: begin
            md_op         = 1'b1;
            md_req.divide = 1'b1;
            md_req.a      = 64'(tm_ff);
            md_req.b      = 64'(ch_mag);
            md_req.den    = bpi_pkg::DEN_STRAIGHT;
         end
         bpi_pkg::ST_SY: begin
            md_op         = 1'b1;
            md_req.divide = 1'b1;
            md_req.a      = 64'(tm_ff);
            md_req.b      = 64'(sh_mag);
            md_req.den    = bpi_pkg::DEN_STRAIGHT;
         end
         bpi_pkg::ST_AB: begin
            md_op    = 1'b1;
            md_req.a = 64'(steer_clip);
            md_req.b = 64'(bpi_pkg::TURN_PER_RAD);
         end
         bpi_pkg::ST_ACORD: begin
            cd_op        = 1'b1;
            cd_req.angle = ab_ff;
         end
         bpi_pkg::ST_GAIN: begin
            md_op         = 1'b1;
            md_req.divide = 1'b1;
            md_req.a      = 64'(sa_ff);
            md_req.b      = 64'(bpi_pkg::TURN_PER_RAD);
            md_req.den    = 64'(ca_ff);
         end
         bpi_pkg::ST_DEN: begin
            md_op    = 1'b1;
            md_req.a = 64'(bpi_pkg::MICRO);
            md_req.b = 64'(len);
         end
         bpi_pkg::ST_DA: begin
            md_op         = 1'b1;
            md_req.divide = 1'b1;
            md_req.a      = 64'(tm_ff);
            md_req.b      = g_ff;
            md_req.den    = den_ff;
         end
         bpi_pkg::ST_DCORD: begin
            cd_op        = 1'b1;
            cd_req.angle = da_ff;
         end
         bpi_pkg::ST_LC: begin
            md_op    = 1'b1;
            md_req.a = 64'(len);
            md_req.b = 64'(ca_ff);
         end
         bpi_pkg::ST_DX: begin
            md_op         = 1'b1;
            md_req.divide = 1'b1;
            md_req.a      = lc_ff;
            md_req.b      = 64'(sd_mag);
            md_req.den    = 64'({sa_ff, 30'd0});
         end
         bpi_pkg::ST_DY: begin
            md_op         = 1'b1;
            md_req.divide = 1'b1;
            md_req.a      = lc_ff;
            md_req.b      = 64'(v_mag);
            md_req.den    = 64'({sa_ff, 30'd0});
         end
         bpi_pkg::ST_RX1: begin
            md_op    = 1'b1;
            md_req.a = 64'(dx_mag);
            md_req.b = 64'(ch_mag);
         end
         bpi_pkg::ST_RX2: begin
            md_op    = 1'b1;
            md_req.a = 64'(dy_mag);
            md_req.b = 64'(sh_mag);
         end
         bpi_pkg::ST_RY1: begin
            md_op    = 1'b1;
            md_req.a = 64'(dx_mag);
            md_req.b = 64'(sh_mag);
         end
         bpi_pkg::ST_RY2: begin
            md_op    = 1'b1;
            md_req.a = 64'(dy_mag);
            md_req.b = 64'(ch_mag);
         end
         default: ;
      endcase
      // Each operation is launched once on entry to its state.
      md_req.start = md_op & ~issued_ff;
      cd_req.start = cd_op & ~issued_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire)       rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign req_ready        = (state_ff == bpi_pkg::ST_IDLE);
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pose_x       = rsp_x_ff;
   assign rsp_pose_y       = rsp_y_ff;
   assign rsp_pose_heading = rsp_head_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpi_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         speed_ff     <= '0;
         steer_ff     <= '0;
         car_len_ff   <= bpi_pkg::CAR_LENGTH_RESET;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= (state_in != state_ff) ? 1'b0
                                                : (issued_ff | md_req.start | cd_req.start);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) car_len_ff <= csr_car_length;
         if (req_valid && req_ready && req_load_control) begin
            speed_ff <= req_new_speed;
            steer_ff <= req_new_steering;
         end
         if (upd_fire) begin
            pos_x_ff <= new_x;
            pos_y_ff <= new_y;
            head_ff  <= head_new;
         end
      end
   end

   // Working and response registers, loaded on a req transfer, a unit result or the update.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) et_ff <= req_elapsed_time;
      if (md_done) begin
         unique case (state_ff)
            bpi_pkg::ST_TIME: begin
               tm_ff   <= md_res[35:0];
               tneg_ff <= speed_ff[15];
            end
            bpi_pkg::ST_SX: begin
               wx_ff <= 64'(clip_local(tneg_ff ^ ch_ff[33], md_res));
               wy_ff <= '0;
            end
            bpi_pkg::ST_SY:   wy_ff  <= 64'(clip_local(tneg_ff ^ sh_ff[33], md_res));
            bpi_pkg::ST_AB:   ab_ff  <= 32'((md_res + 64'd8192) >> 14);
            bpi_pkg::ST_GAIN: g_ff   <= md_res;
            bpi_pkg::ST_DEN:  den_ff <= md_res;
            bpi_pkg::ST_DA:   da_ff  <= tneg_ff ? (32'd0 - md_res[31:0]) : md_res[31:0];
            bpi_pkg::ST_LC:   lc_ff  <= md_res;
            bpi_pkg::ST_DX:   dx_ff  <= clip_local(sd_ff[33], md_res);
            bpi_pkg::ST_DY: begin
               // Turning right mirrors the lateral offset.
               if (steer_ff[15]) dy_ff <= -clip_local(v_q30[34], md_res);
               else              dy_ff <= clip_local(v_q30[34], md_res);
            end
            bpi_pkg::ST_RX1, bpi_pkg::ST_RY1: acc_ff <= rot_prod;
            bpi_pkg::ST_RX2: wx_ff <= 64'(rot_sum >>> 30);
            bpi_pkg::ST_RY2: wy_ff <= 64'(rot_sum >>> 30);
            default: ;
         endcase
      end
      if (cd_done) begin
         unique case (state_ff)
            bpi_pkg::ST_HCORD: begin
               ch_ff <= cd_cos;
               sh_ff <= cd_sin;
            end
            bpi_pkg::ST_ACORD: begin
               // A degenerate sine or cosine is held at one LSB.
               ca_ff <= (cd_cos < 34'sd1) ? 32'd1 : cd_cos[31:0];
               sa_ff <= (cd_sin < 34'sd1) ? 32'd1 : cd_sin[31:0];
            end
            bpi_pkg::ST_DCORD: begin
               cd_ff <= cd_cos;
               sd_ff <= cd_sin;
            end
            default: ;
         endcase
      end
      if (upd_fire) begin
         rsp_x_ff    <= new_x;
         rsp_y_ff    <= new_y;
         rsp_head_ff <= head_new;
         rsp_sat_ff  <= sat_x | sat_y;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bpi_checker.sv
// Port-level checks for the bicycle pose integrator, attached by bind.
// Depends on the bicycle_pose_integrator port list only.
`timescale 1ns / 1ps
`default_nettype none

module bpi_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic signed [31:0] rsp_pose_x,
   input wire logic signed [31:0] rsp_pose_y,
   input wire logic [15:0]        rsp_pose_heading,
   input wire logic               rsp_saturated
);

   // The block works on one step at a time once a transfer is taken.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready stayed high after a req transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pose_x)
                                     && $stable(rsp_pose_y) && $stable(rsp_pose_heading)))
      else $error("stalled rsp changed");

   // A clipped step must leave a coordinate at a range limit.
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_pose_x == 32'sh7FFFFFFF
                                        || rsp_pose_x == 32'sh80000000
                                        || rsp_pose_y == 32'sh7FFFFFFF
                                        || rsp_pose_y == 32'sh80000000))
      else $error("saturated set without a clipped coordinate");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

endmodule

bind bicycle_pose_integrator bpi_checker u_bpi_checker (.*);

`default_nettype wire
